// File: design/ilpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ilpm_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic [7:0] V4_BITS = 8'd32;
    localparam logic [7:0] V6_BITS = 8'd128;
    localparam logic [7:0] HALF_BITS = 8'd64;

    typedef logic [1:0] op_t;
    localparam op_t OP_CLEAR  = 2'd0;
    localparam op_t OP_INSERT = 2'd1;
    localparam op_t OP_LOOKUP = 2'd2;

    typedef logic [1:0] stat_t;
    localparam stat_t STAT_DONE    = 2'd0;
    localparam stat_t STAT_FULL    = 2'd1;
    localparam stat_t STAT_BADLEN  = 2'd2;
    localparam stat_t STAT_NOTHOST = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_EMIT
    } state_t;

    // one table entry, address already in the 128-bit store layout
    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        v6;
        logic [7:0]  len;
    } entry_t;

    // lookup key in store layout
    typedef struct packed {
        logic        v6;
        logic [63:0] hi;
        logic [63:0] lo;
    } query_t;

    // running best candidate of a scan
    typedef struct packed {
        logic       matched;
        logic [7:0] len;
        logic       exact;
    } match_t;

    // result word
    typedef struct packed {
        stat_t      status;
        logic       matched;
        logic [5:0] entry_index;
        logic [7:0] match_len;
        logic       exact;
    } rsp_t;

    // top n bits of a 64-bit word set
    function automatic logic [63:0] top_mask(input logic [7:0] n);
        logic [63:0] ones;
        ones = '1;
        if (n >= HALF_BITS) begin
            top_mask = ones;
        end
        else begin
            top_mask = ~(ones >> n[5:0]);
        end
    endfunction

endpackage

`default_nettype wire

// File: design/ilpm_if.sv
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface ilpm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic        is_v6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  prefix_len;

    modport source (output valid, op, is_v6, addr_hi, addr_lo, prefix_len, input ready);
    modport sink   (input valid, op, is_v6, addr_hi, addr_lo, prefix_len, output ready);
endinterface

// response channel
interface ilpm_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       matched;
    logic [5:0] entry_index;
    logic [7:0] match_len;
    logic       exact;

    modport source (output valid, status, matched, entry_index, match_len, exact, input ready);
    modport sink   (input valid, status, matched, entry_index, match_len, exact, output ready);
endinterface

`default_nettype wire

// File: design/ip_longest_prefix_match.sv
`timescale 1ns / 1ps
`default_nettype none

// clear, insert, unused op: emit loads the response; a new word is taken only in idle
// lookup: scan of the filled entries, wait, emit; as clear when the table is empty or
//   prefix_len is not full; one table entry read per cycle through one read port
// a stalled response holds in the output register; the block waits in emit until it drains
// reset clears entry count, control and output valid; table contents are not cleared

module ip_longest_prefix_match #(
    parameter int TABLE_DEPTH = ilpm_pkg::TABLE_DEPTH_DEF
) (
    input  wire       clk,
    input  wire       rst_n,
    ilpm_req_if.sink  req,
    ilpm_rsp_if.source rsp
);
    import ilpm_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int EXT_W = IDX_W + 6;

    // control state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             out_vld_reg, out_vld_next;

    // payload
    logic [IDX_W-1:0] rd_idx_reg;
    query_t           query_reg, query_next;
    stat_t            res_status_reg, res_status_next;
    logic             res_scan_reg, res_scan_next;
    rsp_t             out_word_reg, out_word_next;

    // request decode
    logic       accept;
    logic [7:0] full_len;
    logic       len_ok;
    logic       tbl_full;
    query_t     req_key;
    entry_t     wr_data;
    logic       wr_en;
    logic       rd_en;
    logic       last_issue;
    logic       slot_free;

    // table read side
    entry_t           rd_data;
    match_t           best;
    logic [IDX_W-1:0] best_idx;
    logic [EXT_W-1:0] best_idx_ext;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        full_len = req.is_v6 ? V6_BITS : V4_BITS;
        len_ok   = (req.prefix_len <= full_len);
        tbl_full = (count_reg >= CNT_W'(TABLE_DEPTH));
        // ipv4 sits in the top 32 bits of the 128-bit layout
        req_key.v6 = req.is_v6;
        req_key.hi = req.is_v6 ? req.addr_hi : {req.addr_lo[31:0], 32'd0};
        req_key.lo = req.is_v6 ? req.addr_lo : 64'd0;

        wr_data.hi  = req_key.hi;
        wr_data.lo  = req_key.lo;
        wr_data.v6  = req.is_v6;
        wr_data.len = req.prefix_len;
        wr_en       = accept && (req.op == OP_INSERT) && len_ok && !tbl_full;
    end

    assign rd_en      = (state_reg == S_SCAN);
    assign last_issue = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);
    assign slot_free  = !out_vld_reg || rsp.ready;

    ilpm_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    // best candidate is cleared on every accepted word, then updated per entry read
    ilpm_match #(
        .IDX_W (IDX_W)
    ) u_match (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (accept),
        .query    (query_reg),
        .vld      (rd_vld_reg),
        .idx      (rd_idx_reg),
        .entry    (rd_data),
        .best     (best),
        .best_idx (best_idx)
    );

    assign best_idx_ext = EXT_W'(best_idx);

    // sequencer: idle takes a word, scan walks the table, wait lets the last read
    // land in the matcher, emit hands the result to the output register
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        query_next      = query_reg;
        res_status_next = res_status_reg;
        res_scan_next   = res_scan_reg;
        out_word_next   = out_word_reg;
        rd_vld_next     = rd_en;
        out_vld_next    = rsp.ready ? 1'b0 : out_vld_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = STAT_DONE;
                    res_scan_next   = 1'b0;
                    state_next      = S_EMIT;
                    case (req.op)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_INSERT:
                        begin
                            // bad length is checked before table full
                            if (!len_ok)
                            begin
                                res_status_next = STAT_BADLEN;
                            end
                            else if (tbl_full)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_LOOKUP:
                        begin
                            query_next = req_key;
                            if (req.prefix_len != full_len)
                            begin
                                res_status_next = STAT_NOTHOST;
                            end
                            else
                            begin
                                res_scan_next = 1'b1;
                                scan_idx_next = '0;
                                if (count_reg != '0)
                                begin
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        default:
                        begin
                            res_status_next = STAT_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (last_issue)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            S_WAIT:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_vld_next          = 1'b1;
                    out_word_next         = '0;
                    out_word_next.status  = res_status_reg;
                    if (res_scan_reg)
                    begin
                        out_word_next.matched     = best.matched;
                        out_word_next.entry_index = best_idx_ext[5:0];
                        out_word_next.match_len   = best.len;
                        out_word_next.exact       = best.exact;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            rd_vld_reg   <= rd_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= scan_idx_reg;
        query_reg      <= query_next;
        res_status_reg <= res_status_next;
        res_scan_reg   <= res_scan_next;
        out_word_reg   <= out_word_next;
    end

    // response port
    assign rsp.valid       = out_vld_reg;
    assign rsp.status      = out_word_reg.status;
    assign rsp.matched     = out_word_reg.matched;
    assign rsp.entry_index = out_word_reg.entry_index;
    assign rsp.match_len   = out_word_reg.match_len;
    assign rsp.exact       = out_word_reg.exact;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> CNT_W'(scan_idx_reg) < count_reg)
        else $error("scan reads beyond filled entries");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == S_SCAN || state_reg == S_WAIT))
        else $error("table read data arrives outside a scan");

    a_match_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.matched |-> rsp.status == STAT_DONE && rsp.match_len <= V6_BITS)
        else $error("match reported with bad status or length");
`endif

endmodule

`default_nettype wire

// File: design/ilpm_table.sv
`timescale 1ns / 1ps
`default_nettype none

module ilpm_table #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  wire                   clk,
    input  wire                   wr_en,
    input  wire  [IDX_W-1:0]      wr_addr,
    input  ilpm_pkg::entry_t      wr_data,
    input  wire                   rd_en,
    input  wire  [IDX_W-1:0]      rd_addr,
    output ilpm_pkg::entry_t      rd_data
);
    import ilpm_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/ilpm_match.sv
`timescale 1ns / 1ps
`default_nettype none

module ilpm_match #(
    parameter int IDX_W = 6
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   clear,
    input  ilpm_pkg::query_t      query,
    input  wire                   vld,
    input  wire  [IDX_W-1:0]      idx,
    input  ilpm_pkg::entry_t      entry,
    output ilpm_pkg::match_t      best,
    output logic [IDX_W-1:0]      best_idx
);
    import ilpm_pkg::*;

    match_t           best_reg;
    match_t           best_next;
    logic [IDX_W-1:0] best_idx_reg;
    logic [IDX_W-1:0] best_idx_next;

    logic [7:0] lo_len;
    logic [7:0] full_len;
    logic       hit;
    logic       take;

    always_comb
    begin
        lo_len   = (entry.len > HALF_BITS) ? (entry.len - HALF_BITS) : 8'd0;
        full_len = entry.v6 ? V6_BITS : V4_BITS;
        // family must agree and the top len bits must cover the host
        hit = vld && (entry.v6 == query.v6)
            && (((entry.hi ^ query.hi) & top_mask(entry.len)) == 64'd0)
            && (((entry.lo ^ query.lo) & top_mask(lo_len)) == 64'd0);
        // strictly longer wins, so the earliest entry keeps a tie
        take = hit && (!best_reg.matched || (entry.len > best_reg.len));

        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        if (clear)
        begin
            best_next     = '0;
            best_idx_next = '0;
        end
        else if (take)
        begin
            best_next.matched = 1'b1;
            best_next.len     = entry.len;
            best_next.exact   = (entry.len == full_len);
            best_idx_next     = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg     <= '0;
            best_idx_reg <= '0;
        end
        else
        begin
            best_reg     <= best_next;
            best_idx_reg <= best_idx_next;
        end
    end

    assign best     = best_reg;
    assign best_idx = best_idx_reg;

endmodule

`default_nettype wire
